FILE: hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define RSI_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication, masked while reset is asserted.
`define RSI_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("check failed");

// Next-cycle implication that also holds across reset.
`define RSI_ASSERT_NXT_ANY(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("check failed");

`endif

FILE: hdl/rsi_pkg.sv
// Shared widths, constants, item type and helpers for the ray/spheroid core.
`timescale 1ns / 1ps
`default_nettype none
package rsi_pkg;

    localparam int CFG_W       = 31;   // reciprocal semi-axis, unsigned Q15.16
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_W        = 32;   // ray fields, signed Q16.16
    localparam int OUT_W       = 31;
    localparam int PROD_W      = 62;   // scaled magnitudes, Q30.32
    localparam int U_W         = 32;   // signed Q.30 components
    localparam int LEN_W       = 6;
    localparam int DOT_W       = 64;   // Q.60 sums
    localparam int R30_W       = 32;
    localparam int W30_W       = 31;
    localparam int SQ_W        = 32;   // root width
    localparam int RAD_W       = 2 * SQ_W;
    localparam int NUM_W       = 34;
    localparam int QUO_W       = 34;
    localparam int DIV_SHIFT   = 28;
    localparam int DVD_W       = NUM_W + DIV_SHIFT;
    localparam int QUEUE_DEPTH = 4;
    localparam int NORM_POINT  = 30;
    localparam int OUT_POINT   = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_EQUATORIAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLAR      = 2'd1;

    localparam logic [CFG_W-1:0]  RECIP_RESET = 31'd65536;
    localparam logic [PROD_W-1:0] ONE_Q32     = 62'h1_0000_0000;
    localparam logic signed [DOT_W-1:0] ONE_Q60 = 64'sh1000_0000_0000_0000;
    localparam logic [OUT_W-1:0]  T_MAX       = 31'h7FFF_FFFF;

    typedef struct packed {
        logic                        fault;
        logic [2:0][U_W-1:0]         u;     // signed origin terms
        logic [2:0][PROD_W-1:0]      qm;    // heading magnitudes
        logic [2:0]                  qn;    // heading signs
        logic [LEN_W-1:0]            len;   // bit length of the largest qm
    } t_item;

    function automatic logic [LEN_W-1:0] bitlen(input logic [PROD_W-1:0] x);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < PROD_W; i++) begin
            if (x[i]) n = LEN_W'(i + 1);
        end
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ray_spheroid_intersection_core.sv
// Usage notes:
// Input channel (i_in_valid / o_in_ready) takes one ray word: origin and
// heading, signed Q16.16. Output channel (o_out_valid / i_out_ready) returns
// one word per ray, in order: exit distance t (unsigned Q15.16, saturating)
// and a fault flag (origin outside, or zero heading; t is 0 then).
// Config channel (i_cfg_valid / o_cfg_ready) writes the reciprocal semi-axes:
// index 0 equatorial, index 1 polar; other indexes are ignored. It is always
// ready; write it only while no ray is in flight.
// Throughput: one ray per cycle, sustained, as long as the receiver keeps up.
// Pipeline, from acceptance to o_out_valid: 2 front stages, 1 queue slot,
// 7 back stages, 32 square-root stages, 1 numerator stage, 34 divide
// stages and the output register.
// When the receiver stalls, the back pipeline holds its contents and the
// result stays on the output; the front keeps accepting until the queue
// (P_QUEUE_DEPTH words) and the front stages are full, then drops o_in_ready.
// Reset sets both reciprocals to 1.0 and empties every stage and the queue.
`timescale 1ns / 1ps
`default_nettype none
module ray_spheroid_intersection_core import rsi_pkg::*; #(
    parameter int P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [IN_W-1:0]       i_origin_x,
    input  logic [IN_W-1:0]       i_origin_y,
    input  logic [IN_W-1:0]       i_origin_z,
    input  logic [IN_W-1:0]       i_heading_x,
    input  logic [IN_W-1:0]       i_heading_y,
    input  logic [IN_W-1:0]       i_heading_z,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_W-1:0]      o_hit_distance,
    output logic                  o_fault,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_W-1:0] r_recip_eq, r_recip_pol;
    logic             fr_valid, q_full, q_avail, q_pop;
    t_item            fr_item, q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recip_eq  <= RECIP_RESET;
            r_recip_pol <= RECIP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_EQUATORIAL: r_recip_eq  <= i_cfg_data[CFG_W-1:0];
                CFG_POLAR:      r_recip_pol <= i_cfg_data[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    rsi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_origin_z  (i_origin_z),
        .i_heading_x (i_heading_x),
        .i_heading_y (i_heading_y),
        .i_heading_z (i_heading_z),
        .i_recip_eq  (r_recip_eq),
        .i_recip_pol (r_recip_pol),
        .o_valid     (fr_valid),
        .i_ready     (!q_full),
        .o_item      (fr_item)
    );

    rsi_queue #(.P_DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid && !q_full),
        .i_item  (fr_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_avail (q_avail),
        .o_item  (q_item)
    );

    rsi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_avail        (q_avail),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_hit_distance (o_hit_distance),
        .o_fault        (o_fault)
    );

endmodule
`default_nettype wire

FILE: hdl/rsi_front.sv
// Front end: scales the ray by the reciprocals and classifies it.
`timescale 1ns / 1ps
`default_nettype none
module rsi_front import rsi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [IN_W-1:0]  i_origin_x,
    input  logic [IN_W-1:0]  i_origin_y,
    input  logic [IN_W-1:0]  i_origin_z,
    input  logic [IN_W-1:0]  i_heading_x,
    input  logic [IN_W-1:0]  i_heading_y,
    input  logic [IN_W-1:0]  i_heading_z,
    input  logic [CFG_W-1:0] i_recip_eq,
    input  logic [CFG_W-1:0] i_recip_pol,
    output logic             o_valid,
    input  logic             i_ready,
    output t_item            o_item
);

    logic                   en;
    logic                   r_v1, r_v2;
    logic [2:0][PROD_W-1:0] r_om, r_qm;
    logic [2:0]             r_on, r_qn;
    t_item                  r_item;
    t_item                  n_item;

    logic [2:0][IN_W-1:0]   org, hdg;
    logic [2:0][CFG_W-1:0]  rcp;
    logic [2:0][IN_W-1:0]   omag, hmag;
    logic [2:0][62:0]       oprod, hprod;
    logic [PROD_W-1:0]      qor;
    logic                   outside;

    assign en      = !r_v2 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v2;
    assign o_item  = r_item;

    assign org = {i_origin_z, i_origin_y, i_origin_x};
    assign hdg = {i_heading_z, i_heading_y, i_heading_x};
    assign rcp = {i_recip_pol, i_recip_eq, i_recip_eq};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            omag[i]  = org[i][IN_W-1] ? (~org[i] + 1'b1) : org[i];
            hmag[i]  = hdg[i][IN_W-1] ? (~hdg[i] + 1'b1) : hdg[i];
            oprod[i] = {31'b0, omag[i]} * {32'b0, rcp[i]};
            hprod[i] = {31'b0, hmag[i]} * {32'b0, rcp[i]};
        end
    end

    // classify: outside if any scaled origin exceeds 1.0, zero heading if all qm are 0
    always_comb begin
        outside = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_om[i] > ONE_Q32) outside = 1'b1;
            n_item.u[i] = r_on[i] ? (U_W'(0) - {1'b0, r_om[i][32:2]})
                                  : {1'b0, r_om[i][32:2]};
        end
        qor          = r_qm[0] | r_qm[1] | r_qm[2];
        n_item.qm    = r_qm;
        n_item.qn    = r_qn;
        n_item.len   = bitlen(qor);
        n_item.fault = outside || (qor == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_om[i] <= oprod[i][PROD_W-1:0];
                r_qm[i] <= hprod[i][PROD_W-1:0];
                r_on[i] <= org[i][IN_W-1];
                r_qn[i] <= hdg[i][IN_W-1];
            end
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/rsi_queue.sv
// Short queue of classified rays between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module rsi_queue import rsi_pkg::*; #(
    parameter int P_DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_avail,
    output t_item o_item
);

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);

    t_item            r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(P_DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == PTR_W'(P_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (i_pop)  r_rd <= (r_rd == PTR_W'(P_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_item;
    end

endmodule
`default_nettype wire

FILE: hdl/rsi_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rsi_sqrt import rsi_pkg::*; #(
    parameter int P_SIDE_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [RAD_W-1:0]    i_radicand,
    input  logic [P_SIDE_W-1:0] i_side,
    output logic                o_valid,
    output logic [SQ_W-1:0]     o_root,
    output logic [P_SIDE_W-1:0] o_side
);

    localparam int RW = SQ_W + 4;

    logic                r_vld  [SQ_W];
    logic [RW-1:0]       r_rem  [SQ_W];
    logic [SQ_W-1:0]     r_root [SQ_W];
    logic [RAD_W-1:0]    r_rad  [SQ_W];
    logic [P_SIDE_W-1:0] r_side [SQ_W];

    for (genvar k = 0; k < SQ_W; k++) begin : g_stage
        logic                p_vld;
        logic [RW-1:0]       p_rem;
        logic [SQ_W-1:0]     p_root;
        logic [RAD_W-1:0]    p_rad;
        logic [P_SIDE_W-1:0] p_side;
        logic [RW-1:0]       cand, trial;

        if (k == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_radicand;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_rad  = r_rad[k-1];
            assign p_side = r_side[k-1];
        end

        // bring down the next two radicand bits and try root*4+1
        assign cand  = {p_rem[RW-3:0], p_rad[RAD_W-1 -: 2]};
        assign trial = RW'({p_root, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k] <= 1'b0;
            else if (i_en) r_vld[k] <= p_vld;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (cand >= trial) begin
                    r_rem[k]  <= cand - trial;
                    r_root[k] <= {p_root[SQ_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= cand;
                    r_root[k] <= {p_root[SQ_W-2:0], 1'b0};
                end
                r_rad[k]  <= {p_rad[RAD_W-3:0], 2'b00};
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[SQ_W-1];
    assign o_root  = r_root[SQ_W-1];
    assign o_side  = r_side[SQ_W-1];

endmodule
`default_nettype wire

FILE: hdl/rsi_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module rsi_div import rsi_pkg::*; #(
    parameter int P_SIDE_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [DVD_W-1:0]    i_dividend,
    input  logic [R30_W-1:0]    i_divisor,
    input  logic [P_SIDE_W-1:0] i_side,
    output logic                o_valid,
    output logic [QUO_W-1:0]    o_quotient,
    output logic [P_SIDE_W-1:0] o_side
);

    logic                r_vld  [QUO_W];
    logic [R30_W-1:0]    r_rem  [QUO_W];
    logic [QUO_W-1:0]    r_lo   [QUO_W];
    logic [R30_W-1:0]    r_dvs  [QUO_W];
    logic [P_SIDE_W-1:0] r_side [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic                p_vld;
        logic [R30_W-1:0]    p_rem;
        logic [QUO_W-1:0]    p_lo;
        logic [R30_W-1:0]    p_dvs;
        logic [P_SIDE_W-1:0] p_side;
        logic [R30_W:0]      cand, diff;
        logic                ge;

        if (k == 0) begin : g_first
            // upper dividend bits start as the partial remainder
            assign p_vld  = i_valid;
            assign p_rem  = R30_W'(i_dividend[DVD_W-1:QUO_W]);
            assign p_lo   = i_dividend[QUO_W-1:0];
            assign p_dvs  = i_divisor;
            assign p_side = i_side;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_lo   = r_lo[k-1];
            assign p_dvs  = r_dvs[k-1];
            assign p_side = r_side[k-1];
        end

        assign cand = {p_rem, p_lo[QUO_W-1]};
        assign diff = cand - {1'b0, p_dvs};
        assign ge   = (cand >= {1'b0, p_dvs});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_vld[k] <= 1'b0;
            else if (i_en) r_vld[k] <= p_vld;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? diff[R30_W-1:0] : cand[R30_W-1:0];
                r_lo[k]   <= {p_lo[QUO_W-2:0], ge};
                r_dvs[k]  <= p_dvs;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid    = r_vld[QUO_W-1];
    assign o_quotient = r_lo[QUO_W-1];
    assign o_side     = r_side[QUO_W-1];

endmodule
`default_nettype wire

FILE: hdl/rsi_back.sv
// Back end: normalization, dot products, root, divide and output scaling.
`timescale 1ns / 1ps
`default_nettype none
module rsi_back import rsi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_hit_distance,
    output logic             o_fault
);

    localparam int SQ_SIDE_W  = R30_W + 1 + R30_W + LEN_W + 1;
    localparam int DIV_SIDE_W = LEN_W + 1;

    logic en;
    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_avail;

    // stage 0: word taken from the queue
    logic  r_v0;
    t_item r_it0;

    // stage 1: normalized heading
    logic                r_v1, r_f1;
    logic [LEN_W-1:0]    r_len1;
    logic [2:0][U_W-1:0] r_u1, r_w1;
    logic [2:0][U_W-1:0] n_w1;
    logic [PROD_W-1:0]   nsh;
    logic [LEN_W-1:0]    sh_r, sh_l;

    // stage 2: products
    logic                    r_v2, r_f2;
    logic [LEN_W-1:0]        r_len2;
    logic signed [DOT_W-1:0] r_puu [3];
    logic signed [DOT_W-1:0] r_puv [3];
    logic signed [DOT_W-1:0] r_pvv [3];

    // stage 3: dot products
    logic                    r_v3, r_f3;
    logic [LEN_W-1:0]        r_len3;
    logic signed [DOT_W-1:0] r_uu, r_uv, r_vv;

    // stage 4: Q.30 terms
    logic               r_v4, r_f4, r_neg4;
    logic [LEN_W-1:0]   r_len4;
    logic [R30_W-1:0]   r_uvm4, r_vv4;
    logic [W30_W-1:0]   r_w4;
    logic [DOT_W-1:0]   uv_abs, wfull;

    // stage 5/6: discriminant
    logic               r_v5, r_f5, r_neg5, r_v6, r_f6, r_neg6;
    logic [LEN_W-1:0]   r_len5, r_len6;
    logic [R30_W-1:0]   r_uvm5, r_vv5, r_uvm6, r_vv6;
    logic [DOT_W-1:0]   r_pa, r_pb, r_dsc;

    // root
    logic                 sq_v;
    logic [SQ_W-1:0]      sq_root;
    logic [SQ_SIDE_W-1:0] sq_side_in, sq_side;
    logic [R30_W-1:0]     sq_uvm, sq_vv;
    logic                 sq_neg, sq_f;
    logic [LEN_W-1:0]     sq_len;

    // numerator
    logic              r_vn, r_fn;
    logic [LEN_W-1:0]  r_lenn;
    logic [NUM_W-1:0]  r_num;
    logic [R30_W-1:0]  r_vvn;

    // divide
    logic                  dv_v, dv_f;
    logic [QUO_W-1:0]      dv_q;
    logic [DIV_SIDE_W-1:0] dv_side;
    logic [LEN_W-1:0]      dv_len;

    // output scaling
    logic [4:0]        sh_up;
    logic [LEN_W-1:0]  sh_dn;
    logic [OUT_W-1:0]  lim;
    logic [QUO_W-1:0]  q_up, q_dn;
    logic [OUT_W-1:0]  n_t;
    logic              r_vo, r_fo;
    logic [OUT_W-1:0]  r_t;

    // heading scaled so the largest magnitude lands in [2^29, 2^30)
    always_comb begin
        sh_r = r_it0.len - LEN_W'(NORM_POINT);
        sh_l = LEN_W'(NORM_POINT) - r_it0.len;
        nsh  = '0;
        for (int i = 0; i < 3; i++) begin
            nsh     = (r_it0.len > LEN_W'(NORM_POINT)) ? (r_it0.qm[i] >> sh_r)
                                                       : (r_it0.qm[i] << sh_l);
            n_w1[i] = r_it0.qn[i] ? (U_W'(0) - {2'b00, nsh[29:0]}) : {2'b00, nsh[29:0]};
        end
    end

    always_comb begin
        uv_abs = r_uv[DOT_W-1] ? (DOT_W'(0) - r_uv) : r_uv;
        wfull  = ONE_Q60 - r_uu;
    end

    assign sq_side_in = {r_uvm6, r_neg6, r_vv6, r_len6, r_f6};
    assign {sq_uvm, sq_neg, sq_vv, sq_len, sq_f} = sq_side;

    rsi_sqrt #(.P_SIDE_W(SQ_SIDE_W)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v6),
        .i_radicand (r_dsc),
        .i_side     (sq_side_in),
        .o_valid    (sq_v),
        .o_root     (sq_root),
        .o_side     (sq_side)
    );

    rsi_div #(.P_SIDE_W(DIV_SIDE_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_vn),
        .i_dividend ({r_num, {DIV_SHIFT{1'b0}}}),
        .i_divisor  (r_vvn),
        .i_side     ({r_lenn, r_fn}),
        .o_valid    (dv_v),
        .o_quotient (dv_q),
        .o_side     (dv_side)
    );

    assign {dv_len, dv_f} = dv_side;

    // result is T28 scaled by 2^(20 - len), saturating
    always_comb begin
        sh_up = 5'(OUT_POINT - int'(dv_len));
        sh_dn = dv_len - LEN_W'(OUT_POINT);
        lim   = T_MAX >> sh_up;
        q_up  = dv_q << sh_up;
        q_dn  = dv_q >> sh_dn;
        if (dv_len <= LEN_W'(OUT_POINT)) begin
            n_t = (dv_q > QUO_W'(lim)) ? T_MAX : q_up[OUT_W-1:0];
        end else begin
            n_t = (q_dn > QUO_W'(T_MAX)) ? T_MAX : q_dn[OUT_W-1:0];
        end
        if (dv_f) n_t = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_vn <= 1'b0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v0 <= i_avail;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_vn <= sq_v;
            r_vo <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_it0  <= i_item;

            r_u1   <= r_it0.u;
            r_w1   <= n_w1;
            r_f1   <= r_it0.fault;
            r_len1 <= r_it0.len;

            for (int i = 0; i < 3; i++) begin
                r_puu[i] <= $signed(r_u1[i]) * $signed(r_u1[i]);
                r_puv[i] <= $signed(r_u1[i]) * $signed(r_w1[i]);
                r_pvv[i] <= $signed(r_w1[i]) * $signed(r_w1[i]);
            end
            r_f2   <= r_f1;
            r_len2 <= r_len1;

            r_uu   <= r_puu[0] + r_puu[1] + r_puu[2];
            r_uv   <= r_puv[0] + r_puv[1] + r_puv[2];
            r_vv   <= r_pvv[0] + r_pvv[1] + r_pvv[2];
            r_f3   <= r_f2;
            r_len3 <= r_len2;

            r_uvm4 <= uv_abs[61:30];
            r_neg4 <= r_uv[DOT_W-1];
            r_vv4  <= r_vv[61:30];
            r_w4   <= wfull[60:30];
            r_f4   <= r_f3 || (r_uu > ONE_Q60);
            r_len4 <= r_len3;

            r_pa   <= r_uvm4 * r_uvm4;
            r_pb   <= r_vv4 * r_w4;
            r_uvm5 <= r_uvm4;
            r_neg5 <= r_neg4;
            r_vv5  <= r_vv4;
            r_f5   <= r_f4;
            r_len5 <= r_len4;

            r_dsc  <= r_pa + r_pb;
            r_uvm6 <= r_uvm5;
            r_neg6 <= r_neg5;
            r_vv6  <= r_vv5;
            r_f6   <= r_f5;
            r_len6 <= r_len5;

            r_num  <= sq_neg ? ({2'b00, sq_root} + {2'b00, sq_uvm})
                             : ({2'b00, sq_root} - {2'b00, sq_uvm});
            r_vvn  <= sq_vv;
            r_fn   <= sq_f;
            r_lenn <= sq_len;

            r_t    <= n_t;
            r_fo   <= dv_f;
        end
    end

    assign o_valid        = r_vo;
    assign o_hit_distance = r_t;
    assign o_fault        = r_fo;

endmodule
`default_nettype wire

FILE: hdl/rsi_checker.sv
// Port-level checker for the ray/spheroid core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rsi_checker import rsi_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic [OUT_W-1:0] o_hit_distance,
    input logic             o_fault
);

    // a stalled result word stays put
    `RSI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_hit_distance) && $stable(o_fault))

    // a faulted ray reports zero distance
    `RSI_ASSERT_IMP(a_fault_zero, i_clk, i_rst_n, o_out_valid && o_fault, o_hit_distance == '0)

    // reset empties the pipeline
    `RSI_ASSERT_NXT_ANY(a_rst_no_out, i_clk, !i_rst_n, !o_out_valid)

    // the front is free right after reset
    `RSI_ASSERT_NXT_ANY(a_rst_ready, i_clk, !i_rst_n, o_in_ready)

endmodule

bind ray_spheroid_intersection_core rsi_checker u_rsi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_hit_distance (o_hit_distance),
    .o_fault        (o_fault)
);
`default_nettype wire
